[sv/trle_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants of the TGA run-length pixel decoder.
package trle_pkg;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 13;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BYTES_PER_PIXEL = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RLE_MODE        = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TOP_DOWN        = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ID_SKIP         = 3'd5;

  localparam int DIM_REG_W = 13;
  localparam int BPP_W     = 3;
  localparam logic [BPP_W-1:0] BPP_RESET = 3'd3;
  localparam logic [BPP_W-1:0] BPP_FOUR  = 3'd4;

  // Input item kinds
  localparam logic FN_DATA = 1'b0;
  localparam logic FN_TICK = 1'b1;

  // Output stream layout
  localparam int ADDR_W   = 26;
  localparam int TDATA_W  = 64;
  localparam int PAD_W    = TDATA_W - 4 * 8 - ADDR_W - 1;
  localparam int PEND_BIT = 4 * 8 + ADDR_W;

  typedef enum logic [1:0] {
    ST_PIXEL     = 2'd0,
    ST_DROP_RUN  = 2'd1,
    ST_AFTER_END = 2'd2
  } status_t;

  // Result fields that do not depend on the image size
  typedef struct packed {
    logic [31:0] colour;   // B, G, R, A from the low byte up
    logic        last;
    logic        pending;
    status_t     status;
  } entry_info_t;

endpackage

[sv/trle_front.sv]
`timescale 1ns / 1ps
// Front end: configuration registers, ID skip, packet parsing and pixel assembly.
module trle_front #(
  parameter int MAX_DIM = 4096,
  parameter int CNT_W   = $clog2(MAX_DIM),
  parameter int DIM_W   = $clog2(MAX_DIM + 1)
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [trle_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [trle_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             in_func,
  input  logic [7:0]                       in_byte,
  output logic                             q_push,
  input  logic                             q_ready,
  output trle_pkg::entry_info_t            q_info,
  output logic [CNT_W-1:0]                 q_x,
  output logic [CNT_W-1:0]                 q_row,
  output logic [DIM_W-1:0]                 dim_w,
  output logic                             four_comp
);
  import trle_pkg::*;

  // Configuration registers
  logic [DIM_REG_W-1:0] image_width;
  logic [DIM_REG_W-1:0] image_height;
  logic [BPP_W-1:0]     bytes_per_pixel;
  logic                 rle_mode;
  logic                 top_down;
  logic [7:0]           id_skip;

  // Decoding state
  logic [7:0]       skip_left, skip_left_next;
  logic [1:0]       phase, phase_next;
  logic             exp_hdr, exp_hdr_next;
  logic             run_flag, run_flag_next;
  logic [7:0]       packet_left, packet_left_next;
  logic [31:0]      colour, colour_next;
  logic [CNT_W-1:0] col_cnt, col_cnt_next;
  logic [CNT_W-1:0] row_cnt, row_cnt_next;
  logic             done, done_next;
  logic             run_ready, run_ready_next;

  logic             restart;
  logic [7:0]       skip_load;
  logic             accept;
  logic             emit;
  logic [31:0]      pix;
  logic [7:0]       pl_dec;
  logic [1:0]       last_phase;
  logic [31:0]      w_ext, h_ext;
  logic [DIM_W-1:0] dim_h;
  logic [DIM_W-1:0] x_inc, y_inc;
  logic             row_end, is_last;

  // Clamp the image size and pick the component count
  always_comb begin
    w_ext = 32'(image_width);
    h_ext = 32'(image_height);
    if (w_ext == 32'd0) begin
      dim_w = DIM_W'(1);
    end else if (w_ext > 32'(MAX_DIM)) begin
      dim_w = DIM_W'(MAX_DIM);
    end else begin
      dim_w = DIM_W'(w_ext);
    end
    if (h_ext == 32'd0) begin
      dim_h = DIM_W'(1);
    end else if (h_ext > 32'(MAX_DIM)) begin
      dim_h = DIM_W'(MAX_DIM);
    end else begin
      dim_h = DIM_W'(h_ext);
    end
  end

  assign four_comp  = (bytes_per_pixel == BPP_FOUR);
  assign last_phase = four_comp ? 2'd3 : 2'd2;

  assign in_ready = q_ready;
  assign accept   = in_valid && in_ready;

  // Position of the current pixel
  assign x_inc   = DIM_W'(col_cnt) + DIM_W'(1);
  assign y_inc   = DIM_W'(row_cnt) + DIM_W'(1);
  assign row_end = (x_inc >= dim_w);
  assign is_last = row_end && (y_inc >= dim_h);

  // Any valid register write restarts decoding
  assign restart   = rst || (cfg_we && (cfg_index <= REG_ID_SKIP));
  assign skip_load = rst ? 8'd0 :
                     (cfg_index == REG_ID_SKIP) ? cfg_wdata[7:0] : id_skip;

  // Classify the transaction and work out the next state
  always_comb begin
    skip_left_next   = skip_left;
    phase_next       = phase;
    exp_hdr_next     = exp_hdr;
    run_flag_next    = run_flag;
    packet_left_next = packet_left;
    colour_next      = colour;
    col_cnt_next     = col_cnt;
    row_cnt_next     = row_cnt;
    done_next        = done;
    run_ready_next   = run_ready;
    emit             = 1'b0;
    pix              = colour;
    pl_dec           = packet_left - 8'd1;
    q_push           = 1'b0;
    q_info           = '0;
    q_x              = '0;
    q_row            = '0;

    if (accept) begin
      if (in_func == FN_TICK) begin
        // Release one more pixel of a pending run
        if (!done && run_ready) begin
          packet_left_next = pl_dec;
          if (pl_dec == 8'd0) begin
            run_ready_next = 1'b0;
            exp_hdr_next   = 1'b1;
          end
          emit = 1'b1;
        end
      end else if (done) begin
        q_push        = 1'b1;
        q_info.status = ST_AFTER_END;
      end else if (run_ready) begin
        q_push         = 1'b1;
        q_info.status  = ST_DROP_RUN;
        q_info.pending = 1'b1;
      end else if (skip_left != 8'd0) begin
        skip_left_next = skip_left - 8'd1;
      end else if (rle_mode && exp_hdr) begin
        // Packet header: run bit and pixel count minus one
        run_flag_next    = in_byte[7];
        packet_left_next = {1'b0, in_byte[6:0]};
        exp_hdr_next     = 1'b0;
        phase_next       = 2'd0;
      end else begin
        // Colour component
        case (phase)
          2'd0:    pix[7:0]   = in_byte;
          2'd1:    pix[15:8]  = in_byte;
          2'd2:    pix[23:16] = in_byte;
          default: pix[31:24] = in_byte;
        endcase
        if (phase == last_phase) begin
          phase_next = 2'd0;
          if (!four_comp) begin
            pix[31:24] = 8'd0;
          end
          if (rle_mode) begin
            if (packet_left == 8'd0) begin
              exp_hdr_next = 1'b1;
            end else if (run_flag) begin
              run_ready_next = 1'b1;
            end else begin
              packet_left_next = pl_dec;
            end
          end
          emit = 1'b1;
        end else begin
          phase_next = phase + 2'd1;
        end
        colour_next = pix;
      end
    end

    // Emit the held colour and advance the raster position
    if (emit) begin
      q_push        = 1'b1;
      q_info.status = ST_PIXEL;
      q_info.colour = four_comp ? pix : {8'd0, pix[23:0]};
      q_info.last   = is_last;
      q_x           = col_cnt;
      q_row         = top_down ? row_cnt :
                      CNT_W'(dim_h - DIM_W'(1) - DIM_W'(row_cnt));
      if (is_last) begin
        done_next      = 1'b1;
        run_ready_next = 1'b0;
      end else if (row_end) begin
        col_cnt_next = '0;
        row_cnt_next = CNT_W'(y_inc);
      end else begin
        col_cnt_next = CNT_W'(x_inc);
      end
      q_info.pending = run_ready_next;
    end
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width     <= DIM_REG_W'(1);
      image_height    <= DIM_REG_W'(1);
      bytes_per_pixel <= BPP_RESET;
      rle_mode        <= 1'b0;
      top_down        <= 1'b0;
      id_skip         <= 8'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:     image_width     <= cfg_wdata[DIM_REG_W-1:0];
        REG_IMAGE_HEIGHT:    image_height    <= cfg_wdata[DIM_REG_W-1:0];
        REG_BYTES_PER_PIXEL: bytes_per_pixel <= cfg_wdata[BPP_W-1:0];
        REG_RLE_MODE:        rle_mode        <= cfg_wdata[0];
        REG_TOP_DOWN:        top_down        <= cfg_wdata[0];
        REG_ID_SKIP:         id_skip         <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  // Decoding state
  always_ff @(posedge clk) begin
    if (restart) begin
      skip_left   <= skip_load;
      phase       <= 2'd0;
      exp_hdr     <= 1'b1;
      run_flag    <= 1'b0;
      packet_left <= 8'd0;
      colour      <= 32'd0;
      col_cnt     <= '0;
      row_cnt     <= '0;
      done        <= 1'b0;
      run_ready   <= 1'b0;
    end else begin
      skip_left   <= skip_left_next;
      phase       <= phase_next;
      exp_hdr     <= exp_hdr_next;
      run_flag    <= run_flag_next;
      packet_left <= packet_left_next;
      colour      <= colour_next;
      col_cnt     <= col_cnt_next;
      row_cnt     <= row_cnt_next;
      done        <= done_next;
      run_ready   <= run_ready_next;
    end
  end

  a_no_run_after_end: assert property (@(posedge clk) disable iff (rst)
    !(done && run_ready))
    else $error("run pending after the final pixel");

  a_phase_in_range: assert property (@(posedge clk) disable iff (rst)
    !four_comp |-> (phase != 2'd3))
    else $error("component phase beyond three-byte pixel");

endmodule

[sv/trle_queue.sv]
`timescale 1ns / 1ps
// Short register queue between the front end and the address back end.
module trle_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             not_full,
  input  logic             pop,
  output logic             head_valid,
  output logic [WIDTH-1:0] head_data
);
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign not_full   = (count != CNT_W'(DEPTH));
  assign head_valid = (count != '0);
  assign head_data  = entries[rd_ptr];
  assign do_push    = push && not_full;
  assign do_pop     = pop && head_valid;

  // Store the pushed entry
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("queue occupancy above depth");

endmodule

[sv/trle_back.sv]
`timescale 1ns / 1ps
// Back end: byte address computation and the registered output stage.
module trle_back #(
  parameter int CNT_W = 12,
  parameter int DIM_W = 13
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          q_valid,
  output logic                          q_pop,
  input  trle_pkg::entry_info_t         q_info,
  input  logic [CNT_W-1:0]              q_x,
  input  logic [CNT_W-1:0]              q_row,
  input  logic [DIM_W-1:0]              dim_w,
  input  logic                          four_comp,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [trle_pkg::TDATA_W-1:0]  m_tdata,
  output logic                          m_tlast,
  output logic [1:0]                    m_tuser
);
  import trle_pkg::*;

  localparam int PROD_W = CNT_W + DIM_W;
  localparam int SUM_W  = PROD_W + 1;
  localparam int SCL_W  = SUM_W + 2;
  localparam int AW     = (SCL_W > ADDR_W) ? SCL_W : ADDR_W;

  logic              s1_valid;
  entry_info_t       s1_info;
  logic [CNT_W-1:0]  s1_x;
  logic [PROD_W-1:0] s1_prod;
  logic              s1_load;
  logic              s2_load;
  logic [SUM_W-1:0]  sum;
  logic [AW-1:0]     scaled;
  logic [ADDR_W-1:0] addr;

  // Stage handshakes
  assign s2_load = s1_valid && (!m_tvalid || m_tready);
  assign s1_load = q_valid && (!s1_valid || s2_load);
  assign q_pop   = s1_load;

  // Pixel offset times three or four components
  assign sum    = SUM_W'(s1_prod) + SUM_W'(s1_x);
  assign scaled = four_comp ? (AW'(sum) << 2) : ((AW'(sum) << 1) + AW'(sum));
  assign addr   = scaled[ADDR_W-1:0];

  // Stage one: row times width
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_load) begin
      s1_valid <= 1'b1;
    end else if (s2_load) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_info <= q_info;
      s1_x    <= q_x;
      s1_prod <= PROD_W'(q_row) * PROD_W'(dim_w);
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s2_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_load) begin
      m_tdata <= {{PAD_W{1'b0}}, s1_info.pending, addr,
                  s1_info.colour[31:24], s1_info.colour[7:0],
                  s1_info.colour[15:8], s1_info.colour[23:16]};
      m_tlast <= s1_info.last;
      m_tuser <= s1_info.status;
    end
  end

  a_flag_is_blank: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tuser != ST_PIXEL)) |-> (m_tdata[PEND_BIT-1:0] == '0))
    else $error("flagged result carries pixel data");

  a_last_not_pending: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tlast) |-> !m_tdata[PEND_BIT])
    else $error("final pixel reports run pixels pending");

endmodule

[sv/tga_rle_pixel_decoder.sv]
`timescale 1ns / 1ps
// Top level of the TGA true-colour raw / run-length pixel decoder.
//
//  channel  dir  handshake           payload
//  s_*      in   s_tvalid/s_tready   tdata: data_byte; tuser: func
//  m_*      out  m_tvalid/m_tready   tdata: pixel, address, pending; tlast; tuser
//  cfg_*    in   cfg_we              cfg_index selects register, cfg_wdata value
//
// One transaction per cycle is taken while the queue is not full; the front end
// decodes in the cycle of acceptance; the multiply for the row offset and the
// output register follow the four-entry queue.
// s_tready drops only while the queue is full, so a stalled output blocks input
// after the queue and the two pipeline registers fill.
// rst (synchronous) and any valid register write restart decoding.
module tga_rle_pixel_decoder #(
  parameter int MAX_DIM     = 4096,
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [7:0]                      s_tdata,   // [7:0] data_byte
  input  logic [0:0]                      s_tuser,   // [0] func
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // [7:0] red, [15:8] green, [23:16] blue, [31:24] alpha,
  // [57:32] byte_address, [58] more_pending, [63:59] zero
  output logic [trle_pkg::TDATA_W-1:0]    m_tdata,
  output logic                            m_tlast,   // last_pixel
  output logic [1:0]                      m_tuser,   // [1:0] status
  input  logic                            cfg_we,
  input  logic [trle_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [trle_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import trle_pkg::*;

  localparam int CNT_W   = $clog2(MAX_DIM);
  localparam int DIM_W   = $clog2(MAX_DIM + 1);
  localparam int ENTRY_W = $bits(entry_info_t) + 2 * CNT_W;

  logic             q_push;
  logic             q_not_full;
  entry_info_t      f_info;
  logic [CNT_W-1:0] f_x;
  logic [CNT_W-1:0] f_row;
  logic [DIM_W-1:0] dim_w;
  logic             four_comp;
  logic             q_pop;
  logic             q_valid;
  logic [ENTRY_W-1:0] q_head;
  entry_info_t      b_info;
  logic [CNT_W-1:0] b_x;
  logic [CNT_W-1:0] b_row;

  trle_front #(
    .MAX_DIM (MAX_DIM),
    .CNT_W   (CNT_W),
    .DIM_W   (DIM_W)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_func   (s_tuser[0]),
    .in_byte   (s_tdata),
    .q_push    (q_push),
    .q_ready   (q_not_full),
    .q_info    (f_info),
    .q_x       (f_x),
    .q_row     (f_row),
    .dim_w     (dim_w),
    .four_comp (four_comp)
  );

  trle_queue #(
    .WIDTH (ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_data  ({f_info, f_x, f_row}),
    .not_full   (q_not_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_data  (q_head)
  );

  // Unpack the queue head
  assign {b_info, b_x, b_row} = q_head;

  trle_back #(
    .CNT_W (CNT_W),
    .DIM_W (DIM_W)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_info    (b_info),
    .q_x       (b_x),
    .q_row     (b_row),
    .dim_w     (dim_w),
    .four_comp (four_comp),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .m_tuser   (m_tuser)
  );

endmodule

[tb/tga_rle_pixel_decoder_test.sv]
`timescale 1ns / 1ps
// Self-checking testbench of the TGA raw / run-length pixel decoder.
module tga_rle_pixel_decoder_test;
  import trle_pkg::*;

  localparam int DIM_LIMIT     = 4096;
  localparam int ITEM_TARGET   = 1850;
  localparam int SETTLE_CYCLES = 8;
  localparam int DRAIN_LIMIT   = 20000;
  localparam int PRINT_LIMIT   = 100;

  // One decoded pixel or flag as it should leave the block
  typedef struct packed {
    logic [7:0]        red;
    logic [7:0]        green;
    logic [7:0]        blue;
    logic [7:0]        alpha;
    logic [ADDR_W-1:0] byte_addr;
    logic              last;
    logic              pending;
    status_t           status;
  } pixel_result_t;

  // Decoder predictor and store of pixels still to arrive
  class pixel_scoreboard;
    logic [DIM_REG_W-1:0] width_reg, height_reg;
    logic [BPP_W-1:0]     bpp_reg;
    logic                 rle_on, top_down_on;
    logic [7:0]           id_skip_reg;

    logic [7:0]  skip_left, packet_left;
    logic [1:0]  phase;
    logic        want_header, run_flag, run_ready, image_done;
    logic [31:0] held_colour;
    int unsigned column, row_idx;

    pixel_result_t pending_pixels[$];
    int unsigned   mismatch_count;
    int unsigned   result_index;

    function new();
      width_reg   = 1;
      height_reg  = 1;
      bpp_reg     = BPP_RESET;
      rle_on      = 0;
      top_down_on = 0;
      id_skip_reg = 0;
      mismatch_count = 0;
      result_index   = 0;
      restart();
    endfunction

    function void restart();
      skip_left   = id_skip_reg;
      phase       = 0;
      want_header = 1;
      run_flag    = 0;
      packet_left = 0;
      held_colour = 0;
      column      = 0;
      row_idx     = 0;
      image_done  = 0;
      run_ready   = 0;
    endfunction

    function int unsigned clamp_dim(logic [DIM_REG_W-1:0] v);
      if (v == 0) return 1;
      if (v > DIM_LIMIT) return DIM_LIMIT;
      return v;
    endfunction

    function int unsigned comps();
      return (bpp_reg == BPP_FOUR) ? 4 : 3;
    endfunction

    function int unsigned pixel_total();
      return clamp_dim(width_reg) * clamp_dim(height_reg);
    endfunction

    function int unsigned outstanding();
      return pending_pixels.size();
    endfunction

    // Mirror a register write; every valid write restarts decoding
    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_IMAGE_WIDTH:     width_reg   = val;
        REG_IMAGE_HEIGHT:    height_reg  = val;
        REG_BYTES_PER_PIXEL: bpp_reg     = val[BPP_W-1:0];
        REG_RLE_MODE:        rle_on      = val[0];
        REG_TOP_DOWN:        top_down_on = val[0];
        REG_ID_SKIP:         id_skip_reg = val[7:0];
        default:             return;
      endcase
      restart();
    endfunction

    function void push_flag(logic pend, status_t st);
      pixel_result_t r;
      r = '0;
      r.pending = pend;
      r.status  = st;
      pending_pixels.push_back(r);
    endfunction

    // Place the held colour at the current position and advance it
    function void emit_pixel();
      pixel_result_t     r;
      int unsigned       w, h, n, x, y, row;
      longint unsigned   offset;
      w = clamp_dim(width_reg);
      h = clamp_dim(height_reg);
      n = comps();
      x = column;
      y = row_idx;
      row = top_down_on ? y : h - 1 - y;
      offset = (longint'(x) + longint'(row) * longint'(w)) * longint'(n);
      r = '0;
      r.red       = held_colour[23:16];
      r.green     = held_colour[15:8];
      r.blue      = held_colour[7:0];
      r.alpha     = (n == 4) ? held_colour[31:24] : 8'd0;
      r.byte_addr = offset[ADDR_W-1:0];
      r.last      = (x + 1 >= w) && (y + 1 >= h);
      r.status    = ST_PIXEL;
      if (r.last) begin
        image_done = 1;
        run_ready  = 0;
      end else if (x + 1 >= w) begin
        column  = 0;
        row_idx = y + 1;
      end else begin
        column = x + 1;
      end
      r.pending = run_ready;
      pending_pixels.push_back(r);
    endfunction

    // Work out what one accepted transaction yields
    function void predict_item(logic func, logic [7:0] data);
      if (func == FN_TICK) begin
        if (image_done || !run_ready) return;
        packet_left = packet_left - 8'd1;
        if (packet_left == 8'd0) begin
          run_ready   = 0;
          want_header = 1;
        end
        emit_pixel();
        return;
      end
      if (image_done) begin
        push_flag(1'b0, ST_AFTER_END);
        return;
      end
      if (run_ready) begin
        push_flag(1'b1, ST_DROP_RUN);
        return;
      end
      if (skip_left > 0) begin
        skip_left = skip_left - 8'd1;
        return;
      end
      if (rle_on && want_header) begin
        run_flag    = data[7];
        packet_left = {1'b0, data[6:0]};
        want_header = 0;
        phase       = 0;
        return;
      end
      // Collect B, G, R(, A) into the held colour
      held_colour[phase*8 +: 8] = data;
      phase = phase + 2'd1;
      if (phase != 0 && phase < comps()) return;
      phase = 0;
      if (comps() == 3) held_colour[31:24] = 8'd0;
      if (rle_on) begin
        if (packet_left == 0) want_header = 1;
        else if (run_flag) run_ready = 1;
        else packet_left = packet_left - 8'd1;
      end
      emit_pixel();
    endfunction

    task flag_mismatch(string msg);
      // cap the printout, keep counting
      if (mismatch_count < PRINT_LIMIT) $display("MISMATCH at %0t: %s", $realtime, msg);
      mismatch_count++;
    endtask

    // Compare one output transaction against the oldest expected pixel
    task check_pixel(logic [TDATA_W-1:0] tdata, logic tlast, logic [1:0] tuser);
      pixel_result_t want;
      result_index++;
      if (pending_pixels.size() == 0) begin
        flag_mismatch($sformatf("result %0d unexpected, tdata=%h", result_index, tdata));
        return;
      end
      want = pending_pixels.pop_front();
      if (tdata[7:0] !== want.red)
        flag_mismatch($sformatf("result %0d red %h, want %h", result_index, tdata[7:0],
                                want.red));
      if (tdata[15:8] !== want.green)
        flag_mismatch($sformatf("result %0d green %h, want %h", result_index, tdata[15:8],
                                want.green));
      if (tdata[23:16] !== want.blue)
        flag_mismatch($sformatf("result %0d blue %h, want %h", result_index, tdata[23:16],
                                want.blue));
      if (tdata[31:24] !== want.alpha)
        flag_mismatch($sformatf("result %0d alpha %h, want %h", result_index, tdata[31:24],
                                want.alpha));
      if (tdata[32 +: ADDR_W] !== want.byte_addr)
        flag_mismatch($sformatf("result %0d address %0d, want %0d", result_index,
                                tdata[32 +: ADDR_W], want.byte_addr));
      if (tdata[PEND_BIT] !== want.pending)
        flag_mismatch($sformatf("result %0d more_pending %b, want %b", result_index,
                                tdata[PEND_BIT], want.pending));
      if (tdata[TDATA_W-1:PEND_BIT+1] !== '0)
        flag_mismatch($sformatf("result %0d padding %h not zero", result_index,
                                tdata[TDATA_W-1:PEND_BIT+1]));
      if (tlast !== want.last)
        flag_mismatch($sformatf("result %0d last_pixel %b, want %b", result_index, tlast,
                                want.last));
      if (tuser !== 2'(want.status))
        flag_mismatch($sformatf("result %0d status %0d, want %0d", result_index, tuser,
                                want.status));
    endtask

    task check_leftover();
      if (pending_pixels.size() != 0)
        flag_mismatch($sformatf("%0d expected results never arrived", pending_pixels.size()));
    endtask
  endclass

  logic                  clk, rst;
  logic                  s_tvalid, s_tready;
  logic [7:0]            s_tdata;
  logic [0:0]            s_tuser;
  logic                  m_tvalid, m_tready;
  logic [TDATA_W-1:0]    m_tdata;
  logic                  m_tlast;
  logic [1:0]            m_tuser;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  pixel_scoreboard sb;
  int unsigned     send_idle_pct, recv_stall_pct, rx_hold_left;
  int unsigned     counted_items;

  tga_rle_pixel_decoder DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .m_tuser(m_tuser),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  // Receiver: random stalls, plus a counted hold-off when one is requested
  initial begin
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold_left > 0) begin
        m_tready <= 1'b0;
        rx_hold_left--;
      end else begin
        m_tready <= !(recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);
      end
    end
  end

  // Check every output transaction
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_pixel(m_tdata, m_tlast, m_tuser);
  end

  // Offer one transaction, idling first at random, and hold until taken
  task send_item(logic func, logic [7:0] data);
    @(negedge clk);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= data;
    s_tuser  <= func;
    do @(posedge clk); while (!s_tready);
    sb.predict_item(func, data);
    counted_items++;
  endtask

  task send_colour();
    repeat (sb.comps()) send_item(FN_DATA, 8'($urandom));
  endtask

  // Send the image-ID bytes that precede the pixel data
  task send_id_bytes();
    repeat (sb.id_skip_reg) send_item(FN_DATA, 8'($urandom));
  endtask

  task stop_sending();
    @(negedge clk);
    s_tvalid <= 1'b0;
  endtask

  task pause_until_drained();
    stop_sending();
    while (sb.outstanding() != 0) @(posedge clk);
  endtask

  task write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    sb.set_register(idx, val);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Wait for the block to go quiet, then load all six registers
  task configure(logic [12:0] w, logic [12:0] h, logic [12:0] bpp, logic [12:0] rle,
                 logic [12:0] td, logic [12:0] skip);
    pause_until_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    write_reg(REG_IMAGE_WIDTH, w);
    write_reg(REG_IMAGE_HEIGHT, h);
    write_reg(REG_BYTES_PER_PIXEL, bpp);
    write_reg(REG_RLE_MODE, rle);
    write_reg(REG_TOP_DOWN, td);
    write_reg(REG_ID_SKIP, skip);
  endtask

  task pick_config();
    logic [12:0] w, h, bpp, skip;
    case ($urandom_range(9))
      0: begin
        w = 13'($urandom_range(DIM_LIMIT - 6, DIM_LIMIT));
        h = 13'($urandom_range(DIM_LIMIT - 6, DIM_LIMIT));
      end
      1: begin
        w = $urandom_range(1) ? 13'd0 : 13'($urandom_range(DIM_LIMIT + 1, 8191));
        h = 13'($urandom_range(0, 4));
      end
      default: begin
        w = 13'($urandom_range(1, 10));
        h = 13'($urandom_range(1, 5));
      end
    endcase
    if ($urandom_range(4) == 0) bpp = 13'($urandom_range(0, 7));
    else bpp = $urandom_range(1) ? 13'(BPP_FOUR) : 13'(BPP_RESET);
    skip = ($urandom_range(14) == 0) ? 13'd255 : 13'($urandom_range(0, 3));
    configure(w, h, bpp, 13'($urandom_range(1)), 13'($urandom_range(1)), skip);
  endtask

  // Feed a mostly well-formed image with occasional stray transactions
  task run_image();
    int unsigned total, target, made, cnt, k;
    logic        is_run;
    total  = sb.pixel_total();
    target = (total <= 48) ? total : $urandom_range(8, 40);
    made   = 0;
    send_id_bytes();
    while (made < target) begin
      if ($urandom_range(19) == 0) send_item(1'($urandom_range(1)), 8'($urandom));
      if (sb.rle_on) begin
        cnt    = ($urandom_range(9) == 0) ? $urandom_range(1, 128) : $urandom_range(1, 6);
        is_run = 1'($urandom_range(1));
        send_item(FN_DATA, {is_run, 7'(cnt - 1)});
        if (is_run) begin
          send_colour();
          for (k = 1; k < cnt; k++) begin
            // stray byte while run pixels wait
            if ($urandom_range(29) == 0) send_item(FN_DATA, 8'($urandom));
            send_item(FN_TICK, 8'($urandom));
          end
        end else begin
          repeat (cnt) send_colour();
        end
        made += cnt;
      end else begin
        send_colour();
        made++;
      end
      if ($urandom_range(59) == 0) pause_until_drained();
    end
    // traffic after a finished image
    if (target == total)
      repeat ($urandom_range(1, 3)) send_item(1'($urandom_range(1)), 8'($urandom));
  endtask

  initial begin
    int unsigned img, guard;
    rst            = 1'b1;
    s_tvalid       = 1'b0;
    s_tdata        = '0;
    s_tuser        = FN_DATA;
    cfg_we         = 1'b0;
    cfg_index      = REG_IMAGE_WIDTH;
    cfg_wdata      = '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    rx_hold_left   = 0;
    counted_items  = 0;
    sb = new();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset settings: one 1x1 raw pixel, then a byte and a tick after the end
    send_item(FN_DATA, 8'hFF);
    send_item(FN_DATA, 8'h00);
    send_item(FN_DATA, 8'hA5);
    send_item(FN_DATA, 8'h3C);
    send_item(FN_TICK, 8'h00);

    // Widest image, 32-bit, bottom-up: skip ID, longest run, byte dropped mid-run
    configure(13'd8191, 13'(DIM_LIMIT), 13'(BPP_FOUR), 13'd1, 13'd0, 13'd2);
    send_item(FN_DATA, 8'h11);
    send_item(FN_DATA, 8'h22);
    send_item(FN_DATA, 8'hFF);
    send_item(FN_DATA, 8'h01);
    send_item(FN_DATA, 8'h02);
    send_item(FN_DATA, 8'h03);
    send_item(FN_DATA, 8'h04);
    send_item(FN_TICK, 8'hFF);
    send_item(FN_TICK, 8'h00);
    send_item(FN_DATA, 8'h55);
    send_item(FN_TICK, 8'h80);

    // Zero width, oversized height, odd component count: raw packet, one-pixel run
    configure(13'd0, 13'd8191, 13'd7, 13'd1, 13'd1, 13'd0);
    send_item(FN_DATA, 8'h00);
    send_item(FN_DATA, 8'h80);
    send_item(FN_DATA, 8'h7F);
    send_item(FN_DATA, 8'hFE);
    send_item(FN_DATA, 8'h80);
    send_item(FN_DATA, 8'h01);
    send_item(FN_DATA, 8'hC3);
    send_item(FN_DATA, 8'h5A);
    send_item(FN_TICK, 8'h7F);

    // Long output hold-off so the block backs up, then a full drain mid-image
    configure(13'd16, 13'd4, 13'(BPP_RESET), 13'd0, 13'd1, 13'd255);
    send_id_bytes();
    rx_hold_left = 100;
    repeat (36) send_item(FN_DATA, 8'($urandom));
    pause_until_drained();
    repeat (158) send_item(FN_DATA, 8'($urandom));

    // Random images, rotating through the idling patterns
    img = 0;
    while (counted_items < ITEM_TARGET) begin
      pick_config();
      case (img % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 73; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 73; end
        default: begin send_idle_pct = 22; recv_stall_pct = 22; end
      endcase
      run_image();
      img++;
    end

    stop_sending();
    guard = 0;
    while (sb.outstanding() != 0 && guard < DRAIN_LIMIT) begin
      @(posedge clk);
      guard++;
    end
    repeat (20) @(posedge clk);
    sb.check_leftover();
    if (sb.mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

[tga_rle_pixel_decoder.f]
sv/trle_pkg.sv
sv/trle_front.sv
sv/trle_queue.sv
sv/trle_back.sv
sv/tga_rle_pixel_decoder.sv
tb/tga_rle_pixel_decoder_test.sv
